/* hdl/cfr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared types and constants of the CAN fragment reassembler: widths, address
// filter values, result status codes, controller states and the command and
// status groups between controller and datapath.
// ----------------------------------------------------------------------------
package cfr_pkg;

  // Default slot table depth
  localparam int NUM_SLOTS_DEF = 64;

  // Field widths
  localparam int ID_W       = 29;
  localparam int DATA_W     = 64;
  localparam int SLOT_OUT_W = 6;
  localparam int SRC_W      = 12;
  localparam int DEST_W     = 12;
  localparam int SEQ_W      = 4;
  localparam int EXP_W      = 5;
  localparam int LEN_W      = 8;
  localparam int STATUS_W   = 2;
  localparam int BYTES      = DATA_W / 8;

  // Address filter and end-of-message marker
  localparam logic [DEST_W-1:0] DEST_OWN   = 12'h001;
  localparam logic [DEST_W-1:0] DEST_BCAST = 12'h000;
  localparam logic [7:0]        END_BYTE   = 8'hFF;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_WORD = 2'd0,
    STAT_SEQ  = 2'd1,
    STAT_FULL = 2'd2
  } status_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_CHECK,
    ST_EMIT_RD,
    ST_EMIT
  } state_e;

  // Slot table write operations
  typedef enum logic [2:0] {
    TBL_NONE,
    TBL_CLEAR,
    TBL_RELEASE,
    TBL_ALLOC,
    TBL_UPDATE
  } tbl_op_e;

  // Result register load operations
  typedef enum logic [1:0] {
    OUT_NONE,
    OUT_FULL,
    OUT_SEQ,
    OUT_WORD
  } out_op_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic    latch;
    logic    idx_inc;
    logic    tbl_rd;
    logic    scan_cmp;
    logic    take_found;
    logic    store;
    logic    word_clr;
    logic    word_inc;
    logic    frag_rd;
    tbl_op_e tbl_op;
    out_op_e out_op;
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic cmd_rel;
    logic rel_ok;
    logic addressed;
    logic scan_last;
    logic cmp_last;
    logic hit;
    logic any_free;
    logic seq_match;
    logic has_ff;
    logic word_last;
  } dp_status_t;

  // One slot table entry
  typedef struct packed {
    logic             valid;
    logic [SRC_W-1:0] src;
    logic [EXP_W-1:0] exp;
  } tbl_entry_t;

endpackage
`default_nettype wire

/* hdl/can_fragment_reassembler.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// can_fragment_reassembler
// Rebuilds messages carried in 8-byte extended CAN frames, one slot per
// source, and emits each complete message as 64-bit words.
// ----------------------------------------------------------------------------
// After reset the block clears every entry of its slot table with busy_o
// high. An item is taken when start_i is high and busy_o low. A release, and
// a frame not addressed to this node, end in the decode state. A frame is
// matched by walking the slot table memory one entry a cycle until a hit or
// the last entry; then the sequence is checked and, if it matches, the
// fragment is stored, and on completion the message words stream out of the
// fragment store one per cycle. Results appear on the result ports for a
// single cycle marked by valid_o, in the cycle after they are formed; the
// receiver cannot stall them, so it must take every valid_o cycle.
// ----------------------------------------------------------------------------
module can_fragment_reassembler
  import cfr_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  output logic                       busy_o,
  input  wire logic                  cmd_i,
  input  wire logic [ID_W-1:0]       can_id_i,
  input  wire logic [DATA_W-1:0]     frame_data_i,
  input  wire logic [SLOT_OUT_W-1:0] release_slot_i,
  output logic                       valid_o,
  output logic [STATUS_W-1:0]        status_o,
  output logic [SLOT_OUT_W-1:0]      slot_o,
  output logic [SRC_W-1:0]           source_addr_o,
  output logic [SEQ_W-1:0]           word_index_o,
  output logic [DATA_W-1:0]          word_data_o,
  output logic [LEN_W-1:0]           msg_length_o,
  output logic                       last_o
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_stat;

  // Sequencer
  cfr_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .stat_i  (dp_stat),
    .cmd_o   (dp_cmd)
  );

  // Tables, stores and result register
  cfr_datapath #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (dp_cmd),
    .stat_o         (dp_stat),
    .cmd_in_i       (cmd_i),
    .can_id_i       (can_id_i),
    .frame_data_i   (frame_data_i),
    .release_slot_i (release_slot_i),
    .valid_o        (valid_o),
    .status_o       (status_o),
    .slot_o         (slot_o),
    .source_addr_o  (source_addr_o),
    .word_index_o   (word_index_o),
    .word_data_o    (word_data_o),
    .msg_length_o   (msg_length_o),
    .last_o         (last_o)
  );

endmodule
`default_nettype wire

/* hdl/cfr_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cfr_datapath
// Input item registers, slot table memory, fragment store memory, search
// bookkeeping, end marker detection and the result register.
// ----------------------------------------------------------------------------
module cfr_datapath
  import cfr_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire dp_cmd_t               cmd_i,
  output dp_status_t                 stat_o,
  input  wire logic                  cmd_in_i,
  input  wire logic [ID_W-1:0]       can_id_i,
  input  wire logic [DATA_W-1:0]     frame_data_i,
  input  wire logic [SLOT_OUT_W-1:0] release_slot_i,
  output logic                       valid_o,
  output logic [STATUS_W-1:0]        status_o,
  output logic [SLOT_OUT_W-1:0]      slot_o,
  output logic [SRC_W-1:0]           source_addr_o,
  output logic [SEQ_W-1:0]           word_index_o,
  output logic [DATA_W-1:0]          word_data_o,
  output logic [LEN_W-1:0]           msg_length_o,
  output logic                       last_o
);

  localparam int SLOT_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int FRAG_DEPTH = NUM_SLOTS * (2 ** SEQ_W);
  localparam int FRAG_AW    = SLOT_W + SEQ_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

  // Latched input item
  logic              cmd_q;
  logic              bcast_q;
  logic [DEST_W-1:0] dest_q;
  logic [SRC_W-1:0]  src_q;
  logic [SEQ_W-1:0]  seq_q;
  logic [DATA_W-1:0] data_q;
  logic [SLOT_OUT_W-1:0] rel_q;

  // Search and slot state
  logic [SLOT_W-1:0] scan_idx_q;
  logic [SLOT_W-1:0] cmp_idx_q;
  logic              have_free_q;
  logic [SLOT_W-1:0] free_idx_q;
  logic [SLOT_W-1:0] slot_q;
  logic [EXP_W-1:0]  exp_q;
  logic [SEQ_W-1:0]  word_q;
  logic [SEQ_W-1:0]  word_d;

  // Memories
  tbl_entry_t        tbl_mem [NUM_SLOTS];
  tbl_entry_t        tbl_rd_q;
  logic [DATA_W-1:0] frag_mem [FRAG_DEPTH];
  logic [DATA_W-1:0] frag_rd_q;

  logic              tbl_we;
  logic [SLOT_W-1:0] tbl_waddr;
  tbl_entry_t        tbl_wdata;
  logic [SLOT_W-1:0] rel_idx;
  logic [SLOT_W-1:0] alloc_idx;
  logic [EXP_W-1:0]  next_exp;

  // End marker search
  logic              has_ff;
  logic [2:0]        ff_pos;
  logic [LEN_W-1:0]  msg_len;

  // Latch the item
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      cmd_q   <= cmd_in_i;
      bcast_q <= can_id_i[28];
      dest_q  <= can_id_i[27:16];
      src_q   <= can_id_i[15:4];
      seq_q   <= can_id_i[3:0];
      data_q  <= frame_data_i;
      rel_q   <= release_slot_i;
    end
  end

  // Scan counters and free slot tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_idx_q  <= '0;
      have_free_q <= 1'b0;
      word_q      <= '0;
    end else begin
      if (cmd_i.latch) begin
        scan_idx_q  <= '0;
        have_free_q <= 1'b0;
      end else if (cmd_i.idx_inc) begin
        scan_idx_q <= scan_idx_q + 1'b1;
      end
      if (cmd_i.scan_cmp && !tbl_rd_q.valid && !have_free_q) begin
        have_free_q <= 1'b1;
      end
      word_q <= word_d;
    end
  end

  always_comb begin
    word_d = word_q;
    if (cmd_i.word_clr) begin
      word_d = '0;
    end else if (cmd_i.word_inc) begin
      word_d = word_q + 1'b1;
    end
  end

  assign alloc_idx = have_free_q ? free_idx_q : cmp_idx_q;
  assign rel_idx   = SLOT_W'(rel_q);

  // Track index of read data, chosen slot and its expected sequence
  always_ff @(posedge clk_i) begin
    if (cmd_i.tbl_rd) begin
      cmp_idx_q <= scan_idx_q;
    end
    if (cmd_i.scan_cmp && !tbl_rd_q.valid && !have_free_q) begin
      free_idx_q <= cmp_idx_q;
    end
    if (cmd_i.take_found) begin
      slot_q <= cmp_idx_q;
      exp_q  <= tbl_rd_q.exp;
    end else if (cmd_i.tbl_op == TBL_ALLOC) begin
      slot_q <= alloc_idx;
      exp_q  <= '0;
    end
  end

  // Find the first end marker byte, first byte at the top
  always_comb begin
    has_ff = 1'b0;
    ff_pos = '0;
    for (int b = BYTES - 1; b >= 0; b--) begin
      if (data_q[DATA_W-1-8*b -: 8] == END_BYTE) begin
        has_ff = 1'b1;
        ff_pos = 3'(b);
      end
    end
  end

  assign msg_len  = {1'b0, seq_q, 3'b000} + LEN_W'(ff_pos) + LEN_W'(1);
  assign next_exp = has_ff ? '0 : ({1'b0, seq_q} + EXP_W'(1));

  // Slot table write select
  always_comb begin
    tbl_we    = 1'b1;
    tbl_waddr = scan_idx_q;
    tbl_wdata = '0;
    case (cmd_i.tbl_op)
      TBL_CLEAR: begin
        tbl_waddr = scan_idx_q;
      end
      TBL_RELEASE: begin
        tbl_waddr = rel_idx;
      end
      TBL_ALLOC: begin
        tbl_waddr = alloc_idx;
        tbl_wdata = '{valid: 1'b1, src: src_q, exp: '0};
      end
      TBL_UPDATE: begin
        tbl_waddr = slot_q;
        tbl_wdata = '{valid: 1'b1, src: src_q, exp: next_exp};
      end
      default: begin
        tbl_we = 1'b0;
      end
    endcase
  end

  // Slot table memory
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= tbl_wdata;
    end
    if (cmd_i.tbl_rd) begin
      tbl_rd_q <= tbl_mem[scan_idx_q];
    end
  end

  // Fragment store memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      frag_mem[{slot_q, seq_q}] <= data_q;
    end
    if (cmd_i.frag_rd) begin
      frag_rd_q <= frag_mem[FRAG_AW'({slot_q, word_d})];
    end
  end

  // Result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= (cmd_i.out_op != OUT_NONE);
    end
  end

  // Result fields
  always_ff @(posedge clk_i) begin
    case (cmd_i.out_op)
      OUT_FULL: begin
        status_o      <= STAT_FULL;
        slot_o        <= '0;
        source_addr_o <= src_q;
        word_index_o  <= seq_q;
        word_data_o   <= '0;
        msg_length_o  <= '0;
        last_o        <= 1'b1;
      end
      OUT_SEQ: begin
        status_o      <= STAT_SEQ;
        slot_o        <= SLOT_OUT_W'(slot_q);
        source_addr_o <= src_q;
        word_index_o  <= seq_q;
        word_data_o   <= '0;
        msg_length_o  <= '0;
        last_o        <= 1'b1;
      end
      OUT_WORD: begin
        status_o      <= STAT_WORD;
        slot_o        <= SLOT_OUT_W'(slot_q);
        source_addr_o <= src_q;
        word_index_o  <= word_q;
        word_data_o   <= frag_rd_q;
        msg_length_o  <= msg_len;
        last_o        <= (word_q == seq_q);
      end
      default: begin
      end
    endcase
  end

  // Status towards the controller
  always_comb begin
    stat_o.cmd_rel   = cmd_q;
    stat_o.rel_ok    = ({26'd0, rel_q} < 32'(NUM_SLOTS));
    stat_o.addressed = (dest_q == DEST_OWN) || (bcast_q && (dest_q == DEST_BCAST));
    stat_o.scan_last = (scan_idx_q == LAST_SLOT);
    stat_o.cmp_last  = (cmp_idx_q == LAST_SLOT);
    stat_o.hit       = tbl_rd_q.valid && (tbl_rd_q.src == src_q);
    stat_o.any_free  = have_free_q || !tbl_rd_q.valid;
    stat_o.seq_match = (exp_q == {1'b0, seq_q});
    stat_o.has_ff    = has_ff;
    stat_o.word_last = (word_q == seq_q);
  end

endmodule
`default_nettype wire

/* hdl/cfr_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cfr_ctrl
// Sequencer of the reassembler: table clearing after reset, decode, slot
// search, sequence check and store, and emission of the message words.
// ----------------------------------------------------------------------------
module cfr_ctrl
  import cfr_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  output logic            busy_o,
  input  wire dp_status_t stat_i,
  output dp_cmd_t         cmd_o
);

  state_e state_q;
  state_e state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (stat_i.scan_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (stat_i.cmd_rel || !stat_i.addressed) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat_i.hit) begin
          state_d = ST_CHECK;
        end else if (stat_i.cmp_last) begin
          state_d = stat_i.any_free ? ST_CHECK : ST_IDLE;
        end
      end
      ST_CHECK: begin
        if (stat_i.seq_match && stat_i.has_ff) begin
          state_d = ST_EMIT_RD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT_RD: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat_i.word_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd_o  = '{tbl_op: TBL_NONE, out_op: OUT_NONE, default: 1'b0};
    busy_o = 1'b1;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.tbl_op  = TBL_CLEAR;
        cmd_o.idx_inc = 1'b1;
      end
      ST_IDLE: begin
        busy_o      = 1'b0;
        cmd_o.latch = start_i;
      end
      ST_DECODE: begin
        if (stat_i.cmd_rel) begin
          if (stat_i.rel_ok) begin
            cmd_o.tbl_op = TBL_RELEASE;
          end
        end else if (stat_i.addressed) begin
          cmd_o.tbl_rd  = 1'b1;
          cmd_o.idx_inc = 1'b1;
        end
      end
      ST_SCAN: begin
        if (stat_i.hit) begin
          cmd_o.take_found = 1'b1;
        end else if (stat_i.cmp_last) begin
          if (stat_i.any_free) begin
            cmd_o.tbl_op = TBL_ALLOC;
          end else begin
            cmd_o.out_op = OUT_FULL;
          end
        end else begin
          cmd_o.scan_cmp = 1'b1;
          cmd_o.tbl_rd   = 1'b1;
          cmd_o.idx_inc  = 1'b1;
        end
      end
      ST_CHECK: begin
        if (!stat_i.seq_match) begin
          cmd_o.out_op = OUT_SEQ;
        end else begin
          cmd_o.store    = 1'b1;
          cmd_o.tbl_op   = TBL_UPDATE;
          cmd_o.word_clr = stat_i.has_ff;
        end
      end
      ST_EMIT_RD: begin
        cmd_o.frag_rd = 1'b1;
      end
      ST_EMIT: begin
        cmd_o.out_op = OUT_WORD;
        if (!stat_i.word_last) begin
          cmd_o.word_inc = 1'b1;
          cmd_o.frag_rd  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire
